// File: sv/drl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the depth-limited reachability block.
// No dependencies; every other file of the block but the checker imports this package.
package drl_pkg;

    // Field widths fixed by the item format.
    localparam int VERTEX_W         = 4;
    localparam int DEPTH_W          = 4;

    // Default graph size and the depth limit after reset.
    localparam int DEF_MAX_VERTICES = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd3;

    // Entries in the queue between the front end and the back end.
    localparam int QUEUE_DEPTH      = 2;

    // Opcodes of an input item.
    localparam logic OP_ADD_EDGE    = 1'b0;
    localparam logic OP_QUERY       = 1'b1;

    // Work kinds handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_EDGE,
        CMD_QUERY,
        CMD_HIT,
        CMD_MISS
    } t_cmd_kind;

    // One queued command: vert_a is the tail or source, vert_b the head or target.
    typedef struct packed {
        t_cmd_kind             kind;
        logic [VERTEX_W-1:0]   vert_a;
        logic [VERTEX_W-1:0]   vert_b;
    } t_cmd;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
    } t_queue_head;

endpackage

// File: sv/drl_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items and classifies them into queued commands.
// Depends on drl_pkg.
module drl_front
    import drl_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                i_in_valid,
    input  logic                i_opcode,
    input  logic [VERTEX_W-1:0] i_edge_from,
    input  logic [VERTEX_W-1:0] i_edge_to,
    input  logic [VERTEX_W-1:0] i_source_vertex,
    input  logic [VERTEX_W-1:0] i_target_vertex,
    input  logic                i_queue_full,
    output logic                o_in_stall,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic accept;
    logic keep;
    logic from_ok;
    logic to_ok;
    logic src_ok;
    logic dst_ok;

    // An item is taken whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // Range checks against the configured graph size.
    assign from_ok = int'(i_edge_from) < MAX_VERTICES;
    assign to_ok   = int'(i_edge_to) < MAX_VERTICES;
    assign src_ok  = int'(i_source_vertex) < MAX_VERTICES;
    assign dst_ok  = int'(i_target_vertex) < MAX_VERTICES;

    // Classify the item; an edge with a vertex out of range is dropped here.
    always_comb begin
        keep         = 1'b1;
        o_cmd.kind   = CMD_EDGE;
        o_cmd.vert_a = i_edge_from;
        o_cmd.vert_b = i_edge_to;
        if (i_opcode == OP_QUERY) begin
            o_cmd.vert_a = i_source_vertex;
            o_cmd.vert_b = i_target_vertex;
            if (i_source_vertex == i_target_vertex) begin
                o_cmd.kind = CMD_HIT;
            end else if (!src_ok || !dst_ok) begin
                o_cmd.kind = CMD_MISS;
            end else begin
                o_cmd.kind = CMD_QUERY;
            end
        end else begin
            keep = from_ok && to_ok;
        end
    end

    assign o_push = accept && keep;

endmodule

// File: sv/drl_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on drl_pkg.
module drl_queue
    import drl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cmd        i_cmd,
    input  logic        i_pop,
    output logic        o_full,
    output t_queue_head o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count; the pop only ever comes with a non-empty queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/drl_engine.sv
`timescale 1ns / 1ps
// Back end: holds the adjacency matrix and the depth limit, runs the
// level-by-level search and drives the result register. Depends on drl_pkg.
module drl_engine
    import drl_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [DEPTH_W-1:0] i_cfg_wr_data,
    input  t_queue_head        i_head,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_found
);

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state                  r_state;
    logic [MAX_VERTICES-1:0] r_rows [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_reached;
    logic [MAX_VERTICES-1:0] n_grown;
    logic [IDX_W-1:0]        r_dst;
    logic [DEPTH_W-1:0]      r_left;
    logic [DEPTH_W-1:0]      r_max_depth;
    logic                    r_out_valid;
    logic                    r_found;
    logic                    out_free;
    logic                    res_set;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    // The result register is free if empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    // An edge needs no result slot; anything else waits for one.
    assign o_pop = (r_state == S_IDLE) && i_head.valid
                   && ((i_head.cmd.kind == CMD_EDGE) || out_free);

    // A result is loaded for a query decided up front or at the end of a search.
    assign res_set = ((r_state == S_IDLE) && o_pop
                      && (i_head.cmd.kind inside {CMD_HIT, CMD_MISS}))
                     || ((r_state == S_SEARCH)
                         && (n_grown[r_dst] || (n_grown == r_reached) || (r_left == '0)));

    // One level of expansion: add every successor of the reached set.
    always_comb begin
        n_grown = r_reached;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            if (r_reached[v]) begin
                n_grown = n_grown | r_rows[v];
            end
        end
    end

    // Sequencer, matrix, depth register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_depth <= DEPTH_RESET;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                r_rows[v] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_max_depth <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_out_stall && !res_set) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.cmd.kind)
                            CMD_EDGE: begin
                                r_rows[IDX_W'(i_head.cmd.vert_a)]
                                      [IDX_W'(i_head.cmd.vert_b)] <= 1'b1;
                            end
                            CMD_QUERY: begin
                                r_reached <= MAX_VERTICES'(1) << IDX_W'(i_head.cmd.vert_a);
                                r_dst     <= IDX_W'(i_head.cmd.vert_b);
                                r_left    <= r_max_depth;
                                r_state   <= S_SEARCH;
                            end
                            CMD_HIT: begin
                                r_out_valid <= 1'b1;
                                r_found     <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_found     <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    // The result slot was emptied when the search began.
                    if (n_grown[r_dst]) begin
                        r_out_valid <= 1'b1;
                        r_found     <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if ((n_grown == r_reached) || (r_left == '0)) begin
                        r_out_valid <= 1'b1;
                        r_found     <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_reached <= n_grown;
                        r_left    <= r_left - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/depth_limited_reachability.sv
`timescale 1ns / 1ps
// Depth-limited reachability over a directed graph of MAX_VERTICES vertices.
// An add-edge item sets one bit of the adjacency matrix and gives no result;
// a query item gives one result, found, which is set when the target equals
// the source or lies within max_depth+1 edges of it. Items enter a two-entry
// queue. The back end applies an add-edge to the matrix and answers a query
// that is decided up front (source equals target, or a vertex out of range)
// directly; any other query loads the source and then searches level by
// level, each level ORing the adjacency rows of every vertex reached so far.
// A query ends early when the target is reached or the reached set stops
// growing, and the back end takes no new item while a search runs. The
// matrix sits in flip-flops that reset clears at once, so the block takes
// items as soon as reset is released.
// Depends on drl_pkg, drl_front, drl_queue and drl_engine.
module depth_limited_reachability
    import drl_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [DEPTH_W-1:0]  i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [VERTEX_W-1:0] i_edge_from,
    input  logic [VERTEX_W-1:0] i_edge_to,
    input  logic [VERTEX_W-1:0] i_source_vertex,
    input  logic [VERTEX_W-1:0] i_target_vertex,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found
);

    logic        push;
    logic        pop;
    logic        queue_full;
    t_cmd        cmd;
    t_queue_head head;

    // Accept and classify.
    drl_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .i_opcode        (i_opcode),
        .i_edge_from     (i_edge_from),
        .i_edge_to       (i_edge_to),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .i_queue_full    (queue_full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    // Decoupling queue.
    drl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    // Matrix update and search.
    drl_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head        (head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found)
    );

endmodule

// File: sv/drl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the depth-limited reachability block, and the bind
// that attaches them to the top level. Watches the handshake and result ports only.
module drl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_found
);

    // A stalled result stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_found))
        else $error("result changed while stalled");

    // Straight out of reset there is neither a result nor back-pressure.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // The queue can only fill up as the result of an accepted item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall raised without an accepted item");

endmodule

bind depth_limited_reachability drl_checker u_drl_checker (.*);
